FILE: hw/rtl/lorenz_euler_integrator_assert.svh
// Assertion macros for the Lorenz Euler integrator.
`ifndef LORENZ_EULER_INTEGRATOR_ASSERT_SVH
`define LORENZ_EULER_INTEGRATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LEI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LEI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lei_pkg.sv
package lei_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS      = 22;
  localparam int OUT_BITS       = 32;
  localparam int COEF_BITS      = 24;
  localparam int DT_BITS        = 24;
  localparam int LEN_BITS       = 16;
  localparam int SCALE_BITS     = 18;
  localparam int ADDR_BITS      = 5;
  localparam int DATA_BITS      = 32;

  localparam logic [COEF_BITS-1:0]  SIGMA_RST = 24'd655360;
  localparam logic [COEF_BITS-1:0]  BETA_RST  = 24'd174758;
  localparam logic [COEF_BITS-1:0]  RHO_RST   = 24'd1835008;
  localparam logic [DT_BITS-1:0]    DT_RST    = 24'd16777;
  localparam logic [LEN_BITS-1:0]   LEN_RST   = 16'd50000;
  localparam logic [SCALE_BITS-1:0] SCALE_RST = 18'd1966;

  typedef enum logic [2:0] {
    REG_SIGMA = 3'd0,
    REG_BETA  = 3'd1,
    REG_RHO   = 3'd2,
    REG_DT    = 3'd3,
    REG_LEN   = 3'd4,
    REG_SCALE = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ROUND,
    ST_POST,
    ST_OUT
  } state_t;

  // One product per entry, in sequencer order.
  typedef enum logic [3:0] {
    OP_DX = 4'd0,
    OP_DY = 4'd1,
    OP_XY = 4'd2,
    OP_BZ = 4'd3,
    OP_NX = 4'd4,
    OP_NY = 4'd5,
    OP_NZ = 4'd6,
    OP_OX = 4'd7,
    OP_OY = 4'd8,
    OP_OZ = 4'd9
  } op_t;

endpackage

FILE: hw/rtl/lorenz_euler_integrator.sv
// Lorenz system, one forward Euler step per transaction, in fixed point.
// Step channel: step_valid/step_stall carry restart; a set restart returns the
// point to (1,1,1) and the step index to 0 before the step is taken.
// Result channel: result_valid/result_stall carry out_x, out_y, out_z (scaled
// point, Q10.22, saturated), step_index and last (final step of the run).
// Configuration: APB port, register i at byte address 4*i, pready tied high.
// The block takes no new step until the current step is through: step_stall is
// high outside the idle state. All ten products go through one shared
// shift-add multiplier that retires one multiplier bit per cycle, with a load
// state before and a rounding and a saturating add or subtract state after each
// product; the output state and the idle state close the step.
// result_valid rises when the output state loads the result after the tenth
// product, later while the result register is still stalled.
// Result stall: a finished result waits in the result register; the next step
// is accepted meanwhile, and its result waits until the register is taken.
// Reset (rst, synchronous) loads the default coefficients, point (1,1,1) and
// step index 0, and drops result_valid.
module lorenz_euler_integrator #(
  parameter int COORD_BITS = lei_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step_valid,
  output logic                               step_stall,
  input  logic                               restart,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [lei_pkg::OUT_BITS-1:0] out_x,
  output logic signed [lei_pkg::OUT_BITS-1:0] out_y,
  output logic signed [lei_pkg::OUT_BITS-1:0] out_z,
  output logic [lei_pkg::LEN_BITS-1:0]        step_index,
  output logic                               last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lei_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [lei_pkg::DATA_BITS-1:0]       pwdata,
  output logic [lei_pkg::DATA_BITS-1:0]       prdata,
  output logic                               pready
);

`include "lorenz_euler_integrator_assert.svh"

  localparam int W  = COORD_BITS;
  localparam int PW = 2 * W + 1;
  localparam int RW = (W > lei_pkg::OUT_BITS) ? W : lei_pkg::OUT_BITS;
  localparam int CW = $clog2(W);
  localparam logic [W-1:0]  ONE_Q   = W'(1) << lei_pkg::FRAC_BITS;
  localparam logic [PW-1:0] LIM_W   = {{(W + 2){1'b0}}, {(W - 1){1'b1}}};
  localparam logic [PW-1:0] LIM_OUT =
    {{(PW - lei_pkg::OUT_BITS + 1){1'b0}}, {(lei_pkg::OUT_BITS - 1){1'b1}}};

  function automatic logic [W:0] sx(input logic [W-1:0] v);
    return {v[W-1], v};
  endfunction

  function automatic logic [W-1:0] sat_w(input logic [W:0] s);
    logic [W-1:0] r;
    if (s[W] != s[W-1]) begin
      r = s[W] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
    end else begin
      r = s[W-1:0];
    end
    return r;
  endfunction

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  lei_pkg::state_t state, state_next;
  lei_pkg::op_t    op;

  logic [lei_pkg::COEF_BITS-1:0]  sigma, beta, rho;
  logic [lei_pkg::DT_BITS-1:0]    time_step;
  logic [lei_pkg::LEN_BITS-1:0]   run_length;
  logic [lei_pkg::SCALE_BITS-1:0] output_scale;

  logic [W-1:0] pos_x, pos_y, pos_z;
  logic [lei_pkg::LEN_BITS-1:0] step_counter;
  logic [W-1:0] t_dx, t_dy, t_dz;
  logic [lei_pkg::OUT_BITS-1:0] res_x, res_y, res_z;

  logic [W-1:0]    mul_a, mul_b;
  logic            mul_neg;
  logic [2*W-1:0]  acc;
  logic [CW-1:0]   cnt;
  logic [RW-1:0]   mres;

  logic            step_take, out_free, out_load, last_w, cfg_wr;
  logic [W-1:0]    diff_yx, rho_z, sig_w, beta_w;
  logic [W+7:0]    rho_d;
  logic [W-1:0]    opa_mag, opb_mag;
  logic            opa_neg, opb_neg;
  logic [PW-1:0]   q, lim, rnd;
  logic            rem_nz;
  logic [W-1:0]    post_a, post_b, post_val;
  logic            post_sub;
  logic [W:0]      post_sum;
  logic [W-1:0]    mres_w;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign step_take = step_valid && !step_stall;
  assign out_free  = !result_valid || !result_stall;
  assign last_w    = ({1'b0, step_counter} + 17'd1) >= {1'b0, run_length};
  assign mres_w    = mres[W-1:0];

  // Operand selection
  assign diff_yx = sat_w(sx(pos_y) - sx(pos_x));
  assign rho_d   = {{(W - 22){rho[lei_pkg::COEF_BITS-1]}}, rho, 6'b0} - {{8{pos_z[W-1]}}, pos_z};
  assign rho_z   = (rho_d[W+7:W-1] == {9{rho_d[W-1]}}) ? rho_d[W-1:0] :
                   (rho_d[W+7] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}});
  assign sig_w   = {{(W - lei_pkg::COEF_BITS){sigma[lei_pkg::COEF_BITS-1]}}, sigma};
  assign beta_w  = {{(W - lei_pkg::COEF_BITS){beta[lei_pkg::COEF_BITS-1]}}, beta};

  always_comb begin
    opa_neg = 1'b0;
    opa_mag = '0;
    opb_neg = 1'b0;
    opb_mag = '0;
    unique case (op)
      lei_pkg::OP_DX: begin
        opa_neg = sig_w[W-1];   opa_mag = mag_of(sig_w);
        opb_neg = diff_yx[W-1]; opb_mag = mag_of(diff_yx);
      end
      lei_pkg::OP_DY: begin
        opa_neg = pos_x[W-1]; opa_mag = mag_of(pos_x);
        opb_neg = rho_z[W-1]; opb_mag = mag_of(rho_z);
      end
      lei_pkg::OP_XY: begin
        opa_neg = pos_x[W-1]; opa_mag = mag_of(pos_x);
        opb_neg = pos_y[W-1]; opb_mag = mag_of(pos_y);
      end
      lei_pkg::OP_BZ: begin
        opa_neg = beta_w[W-1]; opa_mag = mag_of(beta_w);
        opb_neg = pos_z[W-1];  opb_mag = mag_of(pos_z);
      end
      lei_pkg::OP_NX, lei_pkg::OP_NY, lei_pkg::OP_NZ: begin
        opa_mag = {{(W - lei_pkg::DT_BITS){1'b0}}, time_step};
        if (op == lei_pkg::OP_NX) begin
          opb_neg = t_dx[W-1]; opb_mag = mag_of(t_dx);
        end else if (op == lei_pkg::OP_NY) begin
          opb_neg = t_dy[W-1]; opb_mag = mag_of(t_dy);
        end else begin
          opb_neg = t_dz[W-1]; opb_mag = mag_of(t_dz);
        end
      end
      lei_pkg::OP_OX, lei_pkg::OP_OY, lei_pkg::OP_OZ: begin
        opb_mag = {{(W - lei_pkg::SCALE_BITS){1'b0}}, output_scale};
        if (op == lei_pkg::OP_OX) begin
          opa_neg = pos_x[W-1]; opa_mag = mag_of(pos_x);
        end else if (op == lei_pkg::OP_OY) begin
          opa_neg = pos_y[W-1]; opa_mag = mag_of(pos_y);
        end else begin
          opa_neg = pos_z[W-1]; opa_mag = mag_of(pos_z);
        end
      end
      default: begin
        opa_mag = '0;
      end
    endcase
  end

  // Rounding toward minus infinity and saturation of the product
  always_comb begin
    unique case (op)
      lei_pkg::OP_DY, lei_pkg::OP_XY: begin
        q      = {1'b0, acc >> lei_pkg::FRAC_BITS};
        rem_nz = |acc[lei_pkg::FRAC_BITS-1:0];
      end
      lei_pkg::OP_NX, lei_pkg::OP_NY, lei_pkg::OP_NZ: begin
        q      = {1'b0, acc >> lei_pkg::DT_BITS};
        rem_nz = |acc[lei_pkg::DT_BITS-1:0];
      end
      default: begin
        q      = {1'b0, acc >> 16};
        rem_nz = |acc[15:0];
      end
    endcase
    q   = q + PW'(mul_neg && rem_nz);
    lim = (op == lei_pkg::OP_OX || op == lei_pkg::OP_OY || op == lei_pkg::OP_OZ) ?
          LIM_OUT : LIM_W;
    if (mul_neg) begin
      rnd = (q > lim + 1'b1) ? (~(lim + 1'b1) + 1'b1) : (~q + 1'b1);
    end else begin
      rnd = (q > lim) ? lim : q;
    end
  end

  // Saturating add or subtract after each product
  always_comb begin
    post_a   = mres_w;
    post_b   = '0;
    post_sub = 1'b0;
    unique case (op)
      lei_pkg::OP_DY: begin
        post_b = pos_y; post_sub = 1'b1;
      end
      lei_pkg::OP_BZ: begin
        post_a = t_dz; post_b = mres_w; post_sub = 1'b1;
      end
      lei_pkg::OP_NX: post_b = pos_x;
      lei_pkg::OP_NY: post_b = pos_y;
      lei_pkg::OP_NZ: post_b = pos_z;
      default: post_b = '0;
    endcase
    post_sum = post_sub ? (sx(post_a) - sx(post_b)) : (sx(post_a) + sx(post_b));
    post_val = sat_w(post_sum);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lei_pkg::ST_IDLE:  if (step_valid) begin
        state_next = lei_pkg::ST_LOAD;
      end
      lei_pkg::ST_LOAD:  state_next = lei_pkg::ST_MUL;
      lei_pkg::ST_MUL:   if (cnt == '0) begin
        state_next = lei_pkg::ST_ROUND;
      end
      lei_pkg::ST_ROUND: state_next = lei_pkg::ST_POST;
      lei_pkg::ST_POST:  state_next = (op == lei_pkg::OP_OZ) ? lei_pkg::ST_OUT : lei_pkg::ST_LOAD;
      lei_pkg::ST_OUT:   if (out_free) begin
        state_next = lei_pkg::ST_IDLE;
      end
      default: state_next = lei_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    step_stall = (state != lei_pkg::ST_IDLE);
    out_load   = (state == lei_pkg::ST_OUT) && out_free;
  end

  always_comb begin
    unique case (lei_pkg::reg_idx_t'(paddr[4:2]))
      lei_pkg::REG_SIGMA: prdata = {{8{sigma[lei_pkg::COEF_BITS-1]}}, sigma};
      lei_pkg::REG_BETA:  prdata = {{8{beta[lei_pkg::COEF_BITS-1]}}, beta};
      lei_pkg::REG_RHO:   prdata = {{8{rho[lei_pkg::COEF_BITS-1]}}, rho};
      lei_pkg::REG_DT:    prdata = {8'b0, time_step};
      lei_pkg::REG_LEN:   prdata = {16'b0, run_length};
      lei_pkg::REG_SCALE: prdata = {14'b0, output_scale};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lei_pkg::ST_IDLE;
      op           <= lei_pkg::OP_DX;
      result_valid <= 1'b0;
      sigma        <= lei_pkg::SIGMA_RST;
      beta         <= lei_pkg::BETA_RST;
      rho          <= lei_pkg::RHO_RST;
      time_step    <= lei_pkg::DT_RST;
      run_length   <= lei_pkg::LEN_RST;
      output_scale <= lei_pkg::SCALE_RST;
      pos_x        <= ONE_Q;
      pos_y        <= ONE_Q;
      pos_z        <= ONE_Q;
      step_counter <= '0;
    end else begin
      state <= state_next;

      if (cfg_wr) begin
        unique case (lei_pkg::reg_idx_t'(paddr[4:2]))
          lei_pkg::REG_SIGMA: sigma        <= pwdata[lei_pkg::COEF_BITS-1:0];
          lei_pkg::REG_BETA:  beta         <= pwdata[lei_pkg::COEF_BITS-1:0];
          lei_pkg::REG_RHO:   rho          <= pwdata[lei_pkg::COEF_BITS-1:0];
          lei_pkg::REG_DT:    time_step    <= pwdata[lei_pkg::DT_BITS-1:0];
          lei_pkg::REG_LEN:   run_length   <= pwdata[lei_pkg::LEN_BITS-1:0];
          lei_pkg::REG_SCALE: output_scale <= pwdata[lei_pkg::SCALE_BITS-1:0];
          default: ;
        endcase
      end

      if (step_take) begin
        op <= lei_pkg::OP_DX;
        if (restart) begin
          pos_x        <= ONE_Q;
          pos_y        <= ONE_Q;
          pos_z        <= ONE_Q;
          step_counter <= '0;
        end
      end

      if (state == lei_pkg::ST_POST) begin
        unique case (op)
          lei_pkg::OP_DX: t_dx  <= mres_w;
          lei_pkg::OP_DY: t_dy  <= post_val;
          lei_pkg::OP_XY: t_dz  <= mres_w;
          lei_pkg::OP_BZ: t_dz  <= post_val;
          lei_pkg::OP_NX: pos_x <= post_val;
          lei_pkg::OP_NY: pos_y <= post_val;
          lei_pkg::OP_NZ: pos_z <= post_val;
          lei_pkg::OP_OX: res_x <= mres[lei_pkg::OUT_BITS-1:0];
          lei_pkg::OP_OY: res_y <= mres[lei_pkg::OUT_BITS-1:0];
          lei_pkg::OP_OZ: res_z <= mres[lei_pkg::OUT_BITS-1:0];
          default: ;
        endcase
        if (op != lei_pkg::OP_OZ) begin
          op <= lei_pkg::op_t'(op + 4'd1);
        end
      end

      if (out_load) begin
        result_valid <= 1'b1;
        if (last_w) begin
          pos_x        <= ONE_Q;
          pos_y        <= ONE_Q;
          pos_z        <= ONE_Q;
          step_counter <= '0;
        end else begin
          step_counter <= step_counter + 1'b1;
        end
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == lei_pkg::ST_LOAD) begin
      mul_a   <= opa_mag;
      mul_b   <= opb_mag;
      mul_neg <= opa_neg ^ opb_neg;
      acc     <= '0;
      cnt     <= CW'(W - 1);
    end else if (state == lei_pkg::ST_MUL) begin
      acc   <= {acc[2*W-2:0], 1'b0} + (mul_b[W-1] ? {{W{1'b0}}, mul_a} : {(2 * W){1'b0}});
      mul_b <= {mul_b[W-2:0], 1'b0};
      cnt   <= cnt - 1'b1;
    end
    if (state == lei_pkg::ST_ROUND) begin
      mres <= rnd[RW-1:0];
    end
    if (out_load) begin
      out_x      <= res_x;
      out_y      <= res_y;
      out_z      <= res_z;
      step_index <= step_counter;
      last       <= last_w;
    end
  end

  `LEI_ASSERT_NEXT(a_step_starts, step_valid && !step_stall, state == lei_pkg::ST_LOAD && op == lei_pkg::OP_DX, "accepted step did not start at the first product")
  `LEI_ASSERT_SAME(a_valid_from_out, $rose(result_valid), $past(state == lei_pkg::ST_OUT), "result raised outside the output state")
  `LEI_ASSERT_NEXT(a_last_restarts, out_load && last_w, step_counter == '0 && pos_x == ONE_Q, "final step did not restart the run")
  `LEI_ASSERT_SAME(a_mul_done, state == lei_pkg::ST_ROUND, $past(state == lei_pkg::ST_MUL) && $past(cnt) == '0, "rounding before all multiplier bits retired")

endmodule

FILE: sim/lorenz_euler_integrator_tb.sv
`timescale 1ns / 1ps

module lorenz_euler_integrator_tb;

  localparam int COORD_W       = lei_pkg::COORD_BITS_DEF;
  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 400;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 75;

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // First step from (1,1,1) with the reset coefficients and scale.
  localparam logic signed [31:0] FIRST_X = 32'sd125824;
  localparam logic signed [31:0] FIRST_Y = 32'sd129095;
  localparam logic signed [31:0] FIRST_Z = 32'sd125614;

  typedef struct packed {
    logic signed [lei_pkg::OUT_BITS-1:0] x;
    logic signed [lei_pkg::OUT_BITS-1:0] y;
    logic signed [lei_pkg::OUT_BITS-1:0] z;
    logic [lei_pkg::LEN_BITS-1:0]        index;
    logic                                last;
  } lorenz_point_t;

  typedef enum logic {
    ROW_STEP,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [2:0]    reg_sel;
    logic [31:0]   data;
    logic          restart_bit;
    logic          typed;
    lorenz_point_t want;
  } row_t;

  logic                                 clk;
  logic                                 rst;
  logic                                 step_valid;
  logic                                 step_stall;
  logic                                 restart;
  logic                                 result_valid;
  logic                                 result_stall;
  logic signed [lei_pkg::OUT_BITS-1:0]  out_x;
  logic signed [lei_pkg::OUT_BITS-1:0]  out_y;
  logic signed [lei_pkg::OUT_BITS-1:0]  out_z;
  logic [lei_pkg::LEN_BITS-1:0]         step_index;
  logic                                 last;
  logic                                 psel;
  logic                                 penable;
  logic                                 pwrite;
  logic [lei_pkg::ADDR_BITS-1:0]        paddr;
  logic [lei_pkg::DATA_BITS-1:0]        pwdata;
  logic [lei_pkg::DATA_BITS-1:0]        prdata;
  logic                                 pready;

  longint k_sigma, k_beta, k_rho, k_dt, k_len, k_scale;
  longint cur_x, cur_y, cur_z, run_pos;

  lorenz_point_t pending_points[$];
  row_t          rows[$];
  int            mismatches;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            stall_left;
  int            quiet_cycles;

  lorenz_euler_integrator u_top (
    .clk          (clk),
    .rst          (rst),
    .step_valid   (step_valid),
    .step_stall   (step_stall),
    .restart      (restart),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .step_index   (step_index),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint clamp_bits(logic signed [127:0] v, int bits);
    logic signed [127:0] hi;
    hi = (128'sd1 <<< (bits - 1)) - 128'sd1;
    if (v > hi) return longint'(hi);
    if (v < -hi - 128'sd1) return longint'(-hi - 128'sd1);
    return longint'(v);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    logic signed [127:0] wa, wb;
    wa = 128'(a);
    wb = 128'(b);
    return clamp_bits(wa + wb, COORD_W);
  endfunction

  function automatic longint sat_diff(longint a, longint b);
    logic signed [127:0] wa, wb;
    wa = 128'(a);
    wb = 128'(b);
    return clamp_bits(wa - wb, COORD_W);
  endfunction

  function automatic longint mul_shift(longint a, longint b, int sh, int bits);
    logic signed [127:0] wa, wb;
    wa = 128'(a);
    wb = 128'(b);
    return clamp_bits((wa * wb) >>> sh, bits);
  endfunction

  function automatic void rewind_run();
    cur_x = 64'sd1 <<< lei_pkg::FRAC_BITS;
    cur_y = 64'sd1 <<< lei_pkg::FRAC_BITS;
    cur_z = 64'sd1 <<< lei_pkg::FRAC_BITS;
    run_pos = 0;
  endfunction

  function automatic void load_reset_defaults();
    k_sigma = longint'($signed(lei_pkg::SIGMA_RST));
    k_beta  = longint'($signed(lei_pkg::BETA_RST));
    k_rho   = longint'($signed(lei_pkg::RHO_RST));
    k_dt    = longint'(lei_pkg::DT_RST);
    k_len   = longint'(lei_pkg::LEN_RST);
    k_scale = longint'(lei_pkg::SCALE_RST);
    rewind_run();
  endfunction

  function automatic void note_reg_write(logic [2:0] sel, logic [31:0] val);
    unique case (sel)
      lei_pkg::REG_SIGMA: k_sigma = longint'($signed(val[lei_pkg::COEF_BITS-1:0]));
      lei_pkg::REG_BETA:  k_beta  = longint'($signed(val[lei_pkg::COEF_BITS-1:0]));
      lei_pkg::REG_RHO:   k_rho   = longint'($signed(val[lei_pkg::COEF_BITS-1:0]));
      lei_pkg::REG_DT:    k_dt    = longint'(val[lei_pkg::DT_BITS-1:0]);
      lei_pkg::REG_LEN:   k_len   = longint'(val[lei_pkg::LEN_BITS-1:0]);
      lei_pkg::REG_SCALE: k_scale = longint'(val[lei_pkg::SCALE_BITS-1:0]);
      default: ;
    endcase
  endfunction

  function automatic lorenz_point_t predict_euler_step(logic rs);
    longint        nx, ny, nz, dx, dy, dz;
    lorenz_point_t p;
    if (rs) rewind_run();
    dx = mul_shift(k_sigma, sat_diff(cur_y, cur_x), 16, COORD_W);
    dy = sat_diff(mul_shift(cur_x, sat_diff(k_rho * 64, cur_z), lei_pkg::FRAC_BITS, COORD_W),
                  cur_y);
    dz = sat_diff(mul_shift(cur_x, cur_y, lei_pkg::FRAC_BITS, COORD_W),
                  mul_shift(k_beta, cur_z, 16, COORD_W));
    nx = sat_sum(cur_x, mul_shift(k_dt, dx, 24, COORD_W));
    ny = sat_sum(cur_y, mul_shift(k_dt, dy, 24, COORD_W));
    nz = sat_sum(cur_z, mul_shift(k_dt, dz, 24, COORD_W));
    p.x = lei_pkg::OUT_BITS'(mul_shift(nx, k_scale, 16, lei_pkg::OUT_BITS));
    p.y = lei_pkg::OUT_BITS'(mul_shift(ny, k_scale, 16, lei_pkg::OUT_BITS));
    p.z = lei_pkg::OUT_BITS'(mul_shift(nz, k_scale, 16, lei_pkg::OUT_BITS));
    p.index = run_pos[lei_pkg::LEN_BITS-1:0];
    p.last = (run_pos + 1 >= k_len);
    if (p.last) begin
      rewind_run();
    end else begin
      cur_x = nx;
      cur_y = ny;
      cur_z = nz;
      run_pos = run_pos + 1;
    end
    return p;
  endfunction

  function automatic row_t typed_step(logic rs, logic signed [31:0] x, y, z,
                                      logic [15:0] idx, logic fin);
    row_t r;
    r = '0;
    r.kind = ROW_STEP;
    r.restart_bit = rs;
    r.typed = 1'b1;
    r.want.x = x;
    r.want.y = y;
    r.want.z = z;
    r.want.index = idx;
    r.want.last = fin;
    return r;
  endfunction

  function automatic row_t first_step(logic rs, logic fin);
    return typed_step(rs, FIRST_X, FIRST_Y, FIRST_Z, '0, fin);
  endfunction

  function automatic row_t free_step(logic rs);
    row_t r;
    r = '0;
    r.kind = ROW_STEP;
    r.restart_bit = rs;
    return r;
  endfunction

  function automatic row_t write_row(logic [2:0] sel, logic [31:0] data);
    row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.reg_sel = sel;
    r.data = data;
    return r;
  endfunction

  function automatic logic [31:0] random_reg_value(logic [2:0] sel);
    int          pick;
    logic [31:0] mag;
    pick = $urandom_range(9);
    unique case (sel)
      lei_pkg::REG_SIGMA, lei_pkg::REG_BETA, lei_pkg::REG_RHO: begin
        if (pick == 0) return 32'h0080_0000;
        if (pick == 1) return 32'h007F_FFFF;
        if (pick == 2) return $urandom;
        mag = $urandom_range(0, 32 << 16);
        return ($urandom_range(3) == 0) ? -mag : mag;
      end
      lei_pkg::REG_DT: begin
        if (pick == 0) return 32'h0;
        if (pick == 1) return 32'h00FF_FFFF;
        if (pick == 2) return $urandom;
        return $urandom_range(0, 40000);
      end
      lei_pkg::REG_LEN: begin
        if (pick == 0) return 32'h0;
        if (pick == 1) return 32'h1;
        if (pick == 2) return 32'h0000_FFFF;
        if (pick == 3) return $urandom;
        return $urandom_range(1, 30);
      end
      default: begin
        if (pick == 0) return 32'h0;
        if (pick == 1) return 32'h0003_FFFF;
        return $urandom;
      end
    endcase
  endfunction

  task automatic check_point(logic signed [31:0] x, y, z, logic [15:0] idx, logic fin);
    lorenz_point_t want;
    if (pending_points.size() == 0) begin
      $display("%0t unexpected result, step_index %0d", $time, idx);
      mismatches++;
    end else begin
      want = pending_points.pop_front();
      if (x !== want.x) begin
        $display("%0t out_x expected %0d actual %0d", $time, want.x, x);
        mismatches++;
      end
      if (y !== want.y) begin
        $display("%0t out_y expected %0d actual %0d", $time, want.y, y);
        mismatches++;
      end
      if (z !== want.z) begin
        $display("%0t out_z expected %0d actual %0d", $time, want.z, z);
        mismatches++;
      end
      if (idx !== want.index) begin
        $display("%0t step_index expected %0d actual %0d", $time, want.index, idx);
        mismatches++;
      end
      if (fin !== want.last) begin
        $display("%0t last expected %0d actual %0d", $time, want.last, fin);
        mismatches++;
      end
    end
  endtask

  task automatic send_step(logic rs, logic typed, lorenz_point_t want);
    lorenz_point_t model;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      step_valid <= 1'b0;
      restart <= 1'($urandom_range(1));
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    step_valid <= 1'b1;
    restart <= rs;
    do @(posedge clk); while (step_stall);
    model = predict_euler_step(rs);
    pending_points.push_back(typed ? want : model);
  endtask

  task automatic drain_results();
    step_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] sel, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    note_reg_write(sel, data);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure();
    for (int i = lei_pkg::REG_SIGMA; i <= lei_pkg::REG_SCALE; i++)
      write_reg(i[2:0], random_reg_value(i[2:0]));
    if ($urandom_range(2) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
  endtask

  always @(posedge clk) begin
    if (result_valid && !result_stall) check_point(out_x, out_y, out_z, step_index, last);
    if (stall_left > 0)
      stall_left = stall_left - 1;
    else if (!result_stall && recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct)
      stall_left = $urandom_range(1, 15);
    result_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    if ((step_valid && !step_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("lorenz_euler_integrator_tb: FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    step_valid = 1'b0;
    restart = 1'b0;
    result_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    stall_left = 0;
    quiet_cycles = 0;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    load_reset_defaults();

    rows.push_back(first_step(1'b0, 1'b0));
    rows.push_back(free_step(1'b0));
    rows.push_back(free_step(1'b0));
    rows.push_back(first_step(1'b1, 1'b0));
    rows.push_back(first_step(1'b1, 1'b0));
    rows.push_back(free_step(1'b0));
    rows.push_back(free_step(1'b0));
    rows.push_back(free_step(1'b0));
    // shorten the run below the current step index
    rows.push_back(write_row(lei_pkg::REG_LEN, 32'd2));
    rows.push_back(free_step(1'b0));
    rows.push_back(first_step(1'b0, 1'b0));
    rows.push_back(free_step(1'b0));
    rows.push_back(write_row(lei_pkg::REG_LEN, 32'd0));
    rows.push_back(first_step(1'b0, 1'b1));
    rows.push_back(first_step(1'b1, 1'b1));
    rows.push_back(write_row(lei_pkg::REG_SCALE, 32'hFFFC_0000));
    rows.push_back(typed_step(1'b0, '0, '0, '0, '0, 1'b1));
    rows.push_back(write_row(REG_SPARE_LO, 32'h0000_0007));
    rows.push_back(write_row(REG_SPARE_HI, 32'hFFFF_FFFF));
    rows.push_back(typed_step(1'b0, '0, '0, '0, '0, 1'b1));
    rows.push_back(write_row(lei_pkg::REG_SCALE, 32'hFFFF_FFFF));
    rows.push_back(write_row(lei_pkg::REG_LEN, 32'hFFFF_FFFF));
    rows.push_back(write_row(lei_pkg::REG_SIGMA, 32'h5A7F_FFFF));
    rows.push_back(write_row(lei_pkg::REG_BETA, 32'h0080_0000));
    rows.push_back(write_row(lei_pkg::REG_RHO, 32'hFF80_0000));
    rows.push_back(write_row(lei_pkg::REG_DT, 32'hFFFF_FFFF));
    rows.push_back(free_step(1'b1));
    rows.push_back(free_step(1'b0));
    rows.push_back(free_step(1'b0));
    rows.push_back(free_step(1'b0));
    rows.push_back(free_step(1'b0));
    rows.push_back(write_row(lei_pkg::REG_RHO, 32'h007F_FFFF));
    rows.push_back(write_row(lei_pkg::REG_SIGMA, 32'h0080_0000));
    rows.push_back(write_row(lei_pkg::REG_BETA, 32'h007F_FFFF));
    rows.push_back(free_step(1'b1));
    rows.push_back(free_step(1'b0));
    rows.push_back(free_step(1'b0));
    rows.push_back(free_step(1'b0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(rows[i].reg_sel, rows[i].data);
      end else begin
        send_step(rows[i].restart_bit, rows[i].typed, rows[i].want);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      reconfigure();
      if (phase == RANDOM_PHASES - 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
        recv_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(39) == 0) drain_results();
        send_step($urandom_range(9) == 0, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("lorenz_euler_integrator_tb: PASS");
    else
      $display("lorenz_euler_integrator_tb: FAIL");
    $finish;
  end

endmodule
